// ===== design/idc_pkg.sv =====
package idc_pkg;

    // Item kinds on the input channel
    typedef enum logic [2:0] {
        ACT_DIST_RD = 3'd0,
        ACT_DIST_WR = 3'd1,
        ACT_CPU_RD  = 3'd2,
        ACT_CPU_WR  = 3'd3,
        ACT_RAISE   = 3'd4,
        ACT_LOWER   = 3'd5
    } action_t;

    // Enable / pending bank operations
    typedef enum logic [1:0] {
        BANK_SET_EN,
        BANK_CLR_EN,
        BANK_SET_PEND,
        BANK_CLR_PEND
    } bank_op_t;

    localparam logic [9:0]  NO_LINE   = 10'd1023;
    localparam logic [8:0]  IDLE_PRIO = 9'h100;

    // Distributor map
    localparam logic [11:0] D_CTRL      = 12'h000;
    localparam logic [11:0] D_TYPE      = 12'h004;
    localparam logic [11:0] D_SET_EN    = 12'h100;
    localparam logic [11:0] D_CLR_EN    = 12'h180;
    localparam logic [11:0] D_SET_PEND  = 12'h200;
    localparam logic [11:0] D_CLR_PEND  = 12'h280;
    localparam logic [11:0] D_BANK_SPAN = 12'h008;
    localparam logic [11:0] D_PRIO_LO   = 12'h400;
    localparam logic [11:0] D_PRIO_HI   = 12'h45c;
    localparam logic [11:0] D_TGT_LO    = 12'h800;
    localparam logic [11:0] D_TGT_HI    = 12'h85c;
    localparam logic [11:0] D_TRIG_LO   = 12'hc00;
    localparam logic [11:0] D_TRIG_HI   = 12'hc14;
    localparam logic [11:0] D_SGI       = 12'hf00;
    localparam logic [11:0] D_ID0       = 12'hfe0;
    localparam logic [11:0] D_ID1       = 12'hfe4;
    localparam logic [11:0] D_ID2       = 12'hfe8;
    localparam logic [11:0] D_ID3       = 12'hfec;

    localparam logic [31:0] TYPE_VAL = 32'h2;
    localparam logic [31:0] ID0_VAL  = 32'h90;
    localparam logic [31:0] ID1_VAL  = 32'h13;
    localparam logic [31:0] ID2_VAL  = 32'h4;

    // CPU interface map
    localparam logic [11:0] C_CTRL = 12'h000;
    localparam logic [11:0] C_PMR  = 12'h004;
    localparam logic [11:0] C_BPR  = 12'h008;
    localparam logic [11:0] C_IAR  = 12'h00c;
    localparam logic [11:0] C_EOIR = 12'h010;
    localparam logic [11:0] C_RPR  = 12'h014;
    localparam logic [11:0] C_HPPIR = 12'h018;

    localparam logic [2:0] BPR_RST = 3'd3;

endpackage

// ===== design/idc_ram.sv =====
module idc_ram #(
    parameter int DEPTH = 96,
    parameter int WIDTH = 8,
    parameter logic [WIDTH-1:0] RST_VAL = '0
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [WIDTH-1:0] data_reg;
    logic             rvld_reg;

    // storage and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        data_reg <= mem[raddr];
    end

    // per-entry written flags; unwritten entries read as reset value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end else begin
            if (we) begin
                vld_reg[waddr] <= 1'b1;
            end
            rvld_reg <= vld_reg[raddr];
        end
    end

    assign rdata = rvld_reg ? data_reg : RST_VAL;

endmodule

// ===== design/interrupt_distributor_cpu_interface.sv =====
// Reads and writes that leave line state go straight to the result stage. Writes that change line state
// rescan all lines (the scan is skipped with the controller disabled), after one step per write byte lane
// and one more; an acknowledge reads the priority memory first, completion of the running line pops the
// chain, and completion of a preempted line walks the chain to unlink it.
// Throughput: one word at a time; the next is accepted the cycle after the result register loads,
// and an untaken result holds the block. Sync active-low reset clears control state; memories use written flags.
module interrupt_distributor_cpu_interface
    import idc_pkg::*;
#(
    parameter int NUM_LINES = 96
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [11:0] s_offset,
    input  logic [2:0]  s_byte_count,
    input  logic [31:0] s_write_data,
    input  logic [6:0]  s_line,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_access_ok,
    output logic        m_irq_request
);

    localparam int LW = $clog2(NUM_LINES);
    localparam logic [9:0]  N10 = 10'(NUM_LINES);
    localparam logic [7:0]  N8  = 8'(NUM_LINES);
    localparam logic [31:0] N32 = 32'(NUM_LINES);
    localparam logic [LW:0] NSC = (LW+1)'(NUM_LINES);

    typedef enum logic [3:0] {
        S_IDLE, S_BANK, S_PRIO_WR, S_ACK_RD, S_ACK_CHK,
        S_EOI_HEAD, S_EOI_POP, S_EOI_PRIO,
        S_WALK_RD, S_WALK_CHK, S_WALK_WR,
        S_RECOMP, S_SCAN, S_SCAN_END, S_DONE
    } state_t;

    state_t state_reg;

    // architectural state
    logic [NUM_LINES-1:0] en_reg, pend_reg, raised_reg;
    logic [31:0] trig_reg [6];
    logic        dist_en_reg, cpu_en_reg;
    logic [7:0]  pmask_reg;
    logic [2:0]  bpr_reg;
    logic [9:0]  active_reg;
    logic [8:0]  active_prio_reg;
    logic [9:0]  best_reg;
    logic        irq_reg;

    // item working registers
    logic [31:0] data_reg;
    logic [2:0]  cnt_reg;
    logic [2:0]  lane_reg;
    logic [6:0]  rel_reg;
    bank_op_t    bank_op_reg;
    logic [31:0] rd_reg;
    logic        ok_reg;
    logic [LW-1:0] eoi_n_reg, walk_t_reg;
    logic [LW:0]   step_reg;

    // scan unit
    logic [LW:0]   scan_idx_reg;
    logic [LW-1:0] cmp_idx_reg;
    logic          cmp_vld_reg;
    logic [8:0]    bp_reg;
    logic [9:0]    bl_reg;

    // output word
    logic        m_valid_reg;
    logic [31:0] m_rd_reg;
    logic        m_ok_reg;
    logic        m_irq_reg;

    // memory ports
    logic          prio_we, link_we;
    logic [LW-1:0] prio_wa, prio_ra, link_wa, link_ra;
    logic [7:0]    prio_wd, prio_rd;
    logic [9:0]    link_wd, link_rd;

    idc_ram #(.DEPTH(NUM_LINES), .WIDTH(8), .RST_VAL(8'h00)) u_prio (
        .aclk(aclk), .aresetn(aresetn), .we(prio_we), .waddr(prio_wa),
        .wdata(prio_wd), .raddr(prio_ra), .rdata(prio_rd)
    );

    idc_ram #(.DEPTH(NUM_LINES), .WIDTH(10), .RST_VAL(NO_LINE)) u_link (
        .aclk(aclk), .aresetn(aresetn), .we(link_we), .waddr(link_wa),
        .wdata(link_wd), .raddr(link_ra), .rdata(link_rd)
    );

    // address decode of the incoming word
    logic in_bank, in_prio, in_tgt, in_trig;
    logic dist_rd_ok;
    logic [31:0] dist_rd_data;
    logic [2:0] trig_idx;

    always_comb begin
        in_bank = (s_offset >= D_SET_EN    && s_offset <= D_SET_EN + D_BANK_SPAN) ||
                  (s_offset >= D_CLR_EN    && s_offset <= D_CLR_EN + D_BANK_SPAN) ||
                  (s_offset >= D_SET_PEND  && s_offset <= D_SET_PEND + D_BANK_SPAN) ||
                  (s_offset >= D_CLR_PEND  && s_offset <= D_CLR_PEND + D_BANK_SPAN);
        in_prio = s_offset >= D_PRIO_LO && s_offset <= D_PRIO_HI;
        in_tgt  = s_offset >= D_TGT_LO  && s_offset <= D_TGT_HI;
        in_trig = s_offset >= D_TRIG_LO && s_offset <= D_TRIG_HI;
        trig_idx = (s_offset[4:2] > 3'd5) ? 3'd5 : s_offset[4:2];
        dist_rd_ok   = 1'b1;
        dist_rd_data = '0;
        if (s_offset == D_CTRL) begin
            dist_rd_data = {31'd0, dist_en_reg};
        end else if (s_offset == D_TYPE) begin
            dist_rd_data = TYPE_VAL;
        end else if (in_bank || in_prio || in_tgt || s_offset == D_ID3) begin
            dist_rd_data = '0;
        end else if (in_trig) begin
            dist_rd_data = trig_reg[trig_idx];
        end else if (s_offset == D_ID0) begin
            dist_rd_data = ID0_VAL;
        end else if (s_offset == D_ID1) begin
            dist_rd_data = ID1_VAL;
        end else if (s_offset == D_ID2) begin
            dist_rd_data = ID2_VAL;
        end else begin
            dist_rd_ok = 1'b0;
        end
    end

    // current write lane and its byte
    logic [7:0] lane_byte;
    logic       lane_live;
    logic [7:0] bank_base;
    logic [7:0] prio_n;

    always_comb begin
        unique case (lane_reg[1:0])
            2'd0: lane_byte = data_reg[7:0];
            2'd1: lane_byte = data_reg[15:8];
            2'd2: lane_byte = data_reg[23:16];
            default: lane_byte = data_reg[31:24];
        endcase
        if (lane_reg[2]) begin
            lane_byte = '0;
        end
        lane_live = lane_reg < cnt_reg;
        bank_base = {1'b0, rel_reg[3:0], 3'b000} + {2'b00, lane_reg, 3'b000};
        prio_n    = {1'b0, rel_reg} + {5'd0, lane_reg};
    end

    // memory port control
    logic ack_go;
    assign ack_go = {1'b0, prio_rd} < active_prio_reg;

    always_comb begin
        prio_we = 1'b0;
        prio_wa = prio_n[LW-1:0];
        prio_wd = lane_byte;
        link_we = 1'b0;
        link_wa = best_reg[LW-1:0];
        link_wd = active_reg;
        prio_ra = (scan_idx_reg < NSC) ? scan_idx_reg[LW-1:0] : '0;
        link_ra = walk_t_reg;
        unique case (state_reg)
            S_PRIO_WR:  prio_we = lane_live && prio_n < N8;
            S_ACK_RD:   prio_ra = best_reg[LW-1:0];
            S_ACK_CHK:  link_we = ack_go;
            S_EOI_HEAD: link_ra = active_reg[LW-1:0];
            S_EOI_POP:  prio_ra = link_rd[LW-1:0];
            S_WALK_CHK: link_ra = eoi_n_reg;
            S_WALK_WR: begin
                link_we = 1'b1;
                link_wa = walk_t_reg;
                link_wd = link_rd;
            end
            default: ;
        endcase
    end

    assign s_ready = state_reg == S_IDLE;

    // sequencer, state and output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            en_reg          <= '0;
            pend_reg        <= '0;
            raised_reg      <= '0;
            for (int i = 0; i < 6; i++) begin
                trig_reg[i] <= '0;
            end
            dist_en_reg     <= 1'b0;
            cpu_en_reg      <= 1'b0;
            pmask_reg       <= '0;
            bpr_reg         <= BPR_RST;
            active_reg      <= NO_LINE;
            active_prio_reg <= IDLE_PRIO;
            best_reg        <= NO_LINE;
            irq_reg         <= 1'b0;
            cmp_vld_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        data_reg <= s_write_data;
                        cnt_reg  <= s_byte_count;
                        lane_reg <= '0;
                        rd_reg   <= '0;
                        ok_reg   <= 1'b1;
                        state_reg <= S_DONE;
                        unique case (s_action)
                            ACT_DIST_RD: begin
                                rd_reg <= dist_rd_data;
                                ok_reg <= dist_rd_ok;
                            end
                            ACT_DIST_WR: begin
                                if (s_offset == D_CTRL) begin
                                    dist_en_reg <= s_write_data[0];
                                    state_reg   <= S_RECOMP;
                                end else if (in_bank) begin
                                    rel_reg   <= {3'd0, s_offset[3:0]};
                                    bank_op_reg <= bank_op_t'({s_offset[9], s_offset[7]});
                                    state_reg <= S_BANK;
                                end else if (in_prio) begin
                                    rel_reg   <= s_offset[6:0];
                                    state_reg <= S_PRIO_WR;
                                end else if (in_trig) begin
                                    trig_reg[trig_idx] <= s_write_data;
                                end else if (!(in_tgt || s_offset == D_SGI)) begin
                                    ok_reg <= 1'b0;
                                end
                            end
                            ACT_CPU_RD: begin
                                priority case (s_offset)
                                    C_CTRL:  rd_reg <= {31'd0, cpu_en_reg};
                                    C_PMR:   rd_reg <= {24'd0, pmask_reg};
                                    C_BPR:   rd_reg <= {29'd0, bpr_reg};
                                    C_RPR:   rd_reg <= {23'd0, active_prio_reg};
                                    C_HPPIR: rd_reg <= {22'd0, best_reg};
                                    C_IAR: begin
                                        if (best_reg >= N10) begin
                                            rd_reg <= {22'd0, NO_LINE};
                                        end else begin
                                            state_reg <= S_ACK_RD;
                                        end
                                    end
                                    default: ok_reg <= 1'b0;
                                endcase
                            end
                            ACT_CPU_WR: begin
                                priority case (s_offset)
                                    C_CTRL: begin
                                        cpu_en_reg <= s_write_data[0];
                                        state_reg  <= S_RECOMP;
                                    end
                                    C_PMR: begin
                                        pmask_reg <= s_write_data[7:0];
                                        state_reg <= S_RECOMP;
                                    end
                                    C_BPR: begin
                                        bpr_reg   <= s_write_data[2:0];
                                        state_reg <= S_RECOMP;
                                    end
                                    C_EOIR: begin
                                        eoi_n_reg  <= s_write_data[LW-1:0];
                                        walk_t_reg <= active_reg[LW-1:0];
                                        step_reg   <= '0;
                                        if (s_write_data < N32 && active_reg < N10) begin
                                            if (s_write_data[9:0] == active_reg) begin
                                                state_reg <= S_EOI_HEAD;
                                            end else begin
                                                state_reg <= S_WALK_RD;
                                            end
                                        end
                                    end
                                    default: ok_reg <= 1'b0;
                                endcase
                            end
                            ACT_RAISE: begin
                                if (s_line < 7'(NUM_LINES) && !raised_reg[s_line[LW-1:0]]) begin
                                    raised_reg[s_line[LW-1:0]] <= 1'b1;
                                    state_reg <= S_RECOMP;
                                end
                            end
                            ACT_LOWER: begin
                                if (s_line < 7'(NUM_LINES) && raised_reg[s_line[LW-1:0]]) begin
                                    raised_reg[s_line[LW-1:0]] <= 1'b0;
                                    state_reg <= S_RECOMP;
                                end
                            end
                            default: ok_reg <= 1'b0;
                        endcase
                    end
                end

                // one byte lane of enable/pending bits per cycle
                S_BANK: begin
                    if (lane_live) begin
                        for (int k = 0; k < 8; k++) begin
                            if (lane_byte[k] && (bank_base + 8'(k)) < N8) begin
                                unique case (bank_op_reg)
                                    BANK_SET_EN: begin
                                        en_reg[LW'(bank_base + 8'(k))] <= 1'b1;
                                        if (raised_reg[LW'(bank_base + 8'(k))]) begin
                                            pend_reg[LW'(bank_base + 8'(k))] <= 1'b1;
                                        end
                                    end
                                    BANK_CLR_EN:   en_reg[LW'(bank_base + 8'(k))] <= 1'b0;
                                    BANK_SET_PEND: pend_reg[LW'(bank_base + 8'(k))] <= 1'b1;
                                    default:       pend_reg[LW'(bank_base + 8'(k))] <= 1'b0;
                                endcase
                            end
                        end
                        lane_reg <= lane_reg + 3'd1;
                    end else begin
                        state_reg <= S_RECOMP;
                    end
                end

                // one priority byte per cycle through the memory write port
                S_PRIO_WR: begin
                    if (lane_live) begin
                        lane_reg <= lane_reg + 3'd1;
                    end else begin
                        state_reg <= S_RECOMP;
                    end
                end

                S_ACK_RD: state_reg <= S_ACK_CHK;

                S_ACK_CHK: begin
                    if (ack_go) begin
                        pend_reg[best_reg[LW-1:0]] <= 1'b0;
                        active_reg      <= best_reg;
                        active_prio_reg <= {1'b0, prio_rd};
                        rd_reg          <= {22'd0, best_reg};
                        state_reg       <= S_RECOMP;
                    end else begin
                        rd_reg    <= {22'd0, NO_LINE};
                        state_reg <= S_DONE;
                    end
                end

                // completion of the running line: pop the chain
                S_EOI_HEAD: state_reg <= S_EOI_POP;

                S_EOI_POP: begin
                    active_reg <= link_rd;
                    if (link_rd < N10) begin
                        state_reg <= S_EOI_PRIO;
                    end else begin
                        active_prio_reg <= IDLE_PRIO;
                        state_reg       <= S_RECOMP;
                    end
                end

                S_EOI_PRIO: begin
                    active_prio_reg <= {1'b0, prio_rd};
                    state_reg       <= S_RECOMP;
                end

                // completion of a preempted line: walk and unlink
                S_WALK_RD: begin
                    state_reg <= (step_reg < NSC) ? S_WALK_CHK : S_RECOMP;
                end

                S_WALK_CHK: begin
                    if (link_rd >= N10) begin
                        state_reg <= S_RECOMP;
                    end else if (link_rd[LW-1:0] == eoi_n_reg) begin
                        state_reg <= S_WALK_WR;
                    end else begin
                        walk_t_reg <= link_rd[LW-1:0];
                        step_reg   <= step_reg + 1'b1;
                        state_reg  <= S_WALK_RD;
                    end
                end

                S_WALK_WR: state_reg <= S_RECOMP;

                S_RECOMP: begin
                    if (!(cpu_en_reg && dist_en_reg)) begin
                        best_reg  <= NO_LINE;
                        irq_reg   <= 1'b0;
                        state_reg <= S_DONE;
                    end else begin
                        bp_reg       <= IDLE_PRIO;
                        bl_reg       <= NO_LINE;
                        scan_idx_reg <= '0;
                        cmp_vld_reg  <= 1'b0;
                        state_reg    <= S_SCAN;
                    end
                end

                // pipelined scan: read one priority, compare the previous one
                S_SCAN: begin
                    if (cmp_vld_reg && en_reg[cmp_idx_reg] &&
                        (pend_reg[cmp_idx_reg] || raised_reg[cmp_idx_reg]) &&
                        {1'b0, prio_rd} < bp_reg) begin
                        bp_reg <= {1'b0, prio_rd};
                        bl_reg <= 10'(cmp_idx_reg);
                    end
                    cmp_vld_reg <= scan_idx_reg < NSC;
                    cmp_idx_reg <= prio_ra;
                    if (scan_idx_reg == NSC) begin
                        state_reg <= S_SCAN_END;
                    end else begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end

                S_SCAN_END: begin
                    cmp_vld_reg <= 1'b0;
                    if (bp_reg < {1'b0, pmask_reg}) begin
                        best_reg <= bl_reg;
                        irq_reg  <= bp_reg < active_prio_reg;
                    end else begin
                        best_reg <= NO_LINE;
                        irq_reg  <= 1'b0;
                    end
                    state_reg <= S_DONE;
                end

                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_rd_reg    <= ok_reg ? rd_reg : '0;
                        m_ok_reg    <= ok_reg;
                        m_irq_reg   <= irq_reg;
                        state_reg   <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_data   = m_rd_reg;
    assign m_access_ok   = m_ok_reg;
    assign m_irq_request = m_irq_reg;

    // a raised request always names a real line
    a_irq_best: assert property (@(posedge aclk) disable iff (!aresetn)
        irq_reg |-> best_reg < N10)
        else $error("irq raised without a pending line");

    // an empty chain goes with the idle running priority
    a_active_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg >= N10 |-> active_prio_reg == IDLE_PRIO)
        else $error("running priority set with no active line");

    // an accepted word keeps the block busy on the next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready held across an accepted word");

endmodule

// ===== tb/interrupt_distributor_cpu_interface_checker.sv =====
module interrupt_distributor_cpu_interface_checker
    import idc_pkg::*;
#(
    parameter int NUM_LINES = 96
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [11:0] s_offset,
    input  logic [2:0]  s_byte_count,
    input  logic [31:0] s_write_data,
    input  logic [6:0]  s_line,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_read_data,
    input  logic        m_access_ok,
    input  logic        m_irq_request,
    output int          fail_count,
    output int          words_pending,
    output int          words_checked,
    output int          irq_seen,
    output int          ack_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] read_data;
        logic        access_ok;
        logic        irq_request;
    } reply_t;

    reply_t reply_q[$];

    // shadow copy of the controller
    logic       en_b[NUM_LINES];
    logic       pend_b[NUM_LINES];
    logic       raised_b[NUM_LINES];
    logic [7:0] prio_b[NUM_LINES];
    logic [9:0] link_b[NUM_LINES];
    logic [31:0] trig_w[6];
    logic       dist_on, cpu_on, irq_lvl;
    logic [7:0] pmask;
    logic [2:0] bpoint;
    logic [9:0] run_line, best_line;
    logic [8:0] run_prio;

    function automatic logic [7:0] lane(input logic [31:0] d, input int i);
        return i < 4 ? d[8*i +: 8] : 8'h00;
    endfunction

    task automatic rescan_lines();
        logic [8:0] bp;
        logic [9:0] bl;
        bp = IDLE_PRIO;
        bl = NO_LINE;
        best_line = NO_LINE;
        irq_lvl = 1'b0;
        if (cpu_on && dist_on) begin
            for (int n = 0; n < NUM_LINES; n++)
                if (en_b[n] && (pend_b[n] || raised_b[n]) && {1'b0, prio_b[n]} < bp) begin
                    bp = {1'b0, prio_b[n]};
                    bl = 10'(n);
                end
            if (bp < {1'b0, pmask}) begin
                best_line = bl;
                if (bp < run_prio) irq_lvl = 1'b1;
            end
        end
    endtask

    task automatic bank_update(input int base, input int cnt, input logic [31:0] d,
                               input bank_op_t op);
        logic [7:0] b;
        int n;
        for (int i = 0; i < cnt; i++) begin
            b = lane(d, i);
            for (int k = 0; k < 8; k++) begin
                n = base + 8 * i + k;
                if (b[k] && n < NUM_LINES) begin
                    case (op)
                        BANK_SET_EN: begin
                            en_b[n] = 1'b1;
                            if (raised_b[n]) pend_b[n] = 1'b1;
                        end
                        BANK_CLR_EN:   en_b[n] = 1'b0;
                        BANK_SET_PEND: pend_b[n] = 1'b1;
                        default:       pend_b[n] = 1'b0;
                    endcase
                end
            end
        end
        rescan_lines();
    endtask

    task automatic take_ack(output logic [31:0] rd);
        int n;
        n = int'(best_line);
        if (n >= NUM_LINES || {1'b0, prio_b[n]} >= run_prio) begin
            rd = {22'd0, NO_LINE};
        end else begin
            link_b[n] = run_line;
            pend_b[n] = 1'b0;
            run_line = 10'(n);
            run_prio = {1'b0, prio_b[n]};
            rescan_lines();
            rd = 32'(n);
            ack_hits++;
        end
    endtask

    task automatic retire_line(input logic [31:0] n);
        int t;
        int nx;
        if (n >= NUM_LINES || run_line >= NUM_LINES) return;
        if (n != {22'd0, run_line}) begin
            t = int'(run_line);
            for (int s = 0; s < NUM_LINES; s++) begin
                nx = int'(link_b[t]);
                if (nx >= NUM_LINES) break;
                if (nx == n) begin
                    link_b[t] = link_b[n];
                    break;
                end
                t = nx;
            end
        end else begin
            run_line = link_b[run_line];
            run_prio = run_line < NUM_LINES ? {1'b0, prio_b[run_line]} : IDLE_PRIO;
        end
        rescan_lines();
    endtask

    function automatic logic in_rng(input logic [11:0] o, input logic [11:0] lo,
                                    input logic [11:0] hi);
        return o >= lo && o <= hi;
    endfunction

    task automatic predict_word(input logic [2:0] act, input logic [11:0] off,
                                input logic [2:0] cnt, input logic [31:0] d,
                                input logic [6:0] ln);
        reply_t r;
        logic [31:0] rd;
        logic ok;
        rd = '0;
        ok = 1'b0;
        case (act)
            ACT_DIST_RD: begin
                ok = 1'b1;
                if (off == D_CTRL) rd = {31'd0, dist_on};
                else if (off == D_TYPE) rd = TYPE_VAL;
                else if (in_rng(off, D_SET_EN, D_SET_EN + D_BANK_SPAN) ||
                         in_rng(off, D_CLR_EN, D_CLR_EN + D_BANK_SPAN) ||
                         in_rng(off, D_SET_PEND, D_SET_PEND + D_BANK_SPAN) ||
                         in_rng(off, D_CLR_PEND, D_CLR_PEND + D_BANK_SPAN) ||
                         in_rng(off, D_PRIO_LO, D_PRIO_HI) ||
                         in_rng(off, D_TGT_LO, D_TGT_HI) || off == D_ID3) rd = '0;
                else if (in_rng(off, D_TRIG_LO, D_TRIG_HI)) rd = trig_w[off[4:2]];
                else if (off == D_ID0) rd = ID0_VAL;
                else if (off == D_ID1) rd = ID1_VAL;
                else if (off == D_ID2) rd = ID2_VAL;
                else ok = 1'b0;
            end
            ACT_DIST_WR: begin
                ok = 1'b1;
                if (off == D_CTRL) begin
                    dist_on = d[0];
                    rescan_lines();
                end else if (in_rng(off, D_SET_EN, D_SET_EN + D_BANK_SPAN))
                    bank_update(int'(off - D_SET_EN) * 8, int'(cnt), d, BANK_SET_EN);
                else if (in_rng(off, D_CLR_EN, D_CLR_EN + D_BANK_SPAN))
                    bank_update(int'(off - D_CLR_EN) * 8, int'(cnt), d, BANK_CLR_EN);
                else if (in_rng(off, D_SET_PEND, D_SET_PEND + D_BANK_SPAN))
                    bank_update(int'(off - D_SET_PEND) * 8, int'(cnt), d, BANK_SET_PEND);
                else if (in_rng(off, D_CLR_PEND, D_CLR_PEND + D_BANK_SPAN))
                    bank_update(int'(off - D_CLR_PEND) * 8, int'(cnt), d, BANK_CLR_PEND);
                else if (in_rng(off, D_PRIO_LO, D_PRIO_HI)) begin
                    for (int i = 0; i < cnt; i++)
                        if (int'(off - D_PRIO_LO) + i < NUM_LINES)
                            prio_b[int'(off - D_PRIO_LO) + i] = lane(d, i);
                    rescan_lines();
                end else if (in_rng(off, D_TGT_LO, D_TGT_HI) || off == D_SGI) ok = 1'b1;
                else if (in_rng(off, D_TRIG_LO, D_TRIG_HI)) trig_w[off[4:2]] = d;
                else ok = 1'b0;
            end
            ACT_CPU_RD: begin
                ok = 1'b1;
                case (off)
                    C_CTRL:  rd = {31'd0, cpu_on};
                    C_PMR:   rd = {24'd0, pmask};
                    C_BPR:   rd = {29'd0, bpoint};
                    C_IAR:   take_ack(rd);
                    C_RPR:   rd = {23'd0, run_prio};
                    C_HPPIR: rd = {22'd0, best_line};
                    default: ok = 1'b0;
                endcase
            end
            ACT_CPU_WR: begin
                ok = 1'b1;
                case (off)
                    C_CTRL: begin cpu_on = d[0]; rescan_lines(); end
                    C_PMR:  begin pmask = d[7:0]; rescan_lines(); end
                    C_BPR:  begin bpoint = d[2:0]; rescan_lines(); end
                    C_EOIR: retire_line(d);
                    default: ok = 1'b0;
                endcase
            end
            ACT_RAISE: begin
                ok = 1'b1;
                if (ln < NUM_LINES && !raised_b[ln]) begin
                    raised_b[ln] = 1'b1;
                    rescan_lines();
                end
            end
            ACT_LOWER: begin
                ok = 1'b1;
                if (ln < NUM_LINES && raised_b[ln]) begin
                    raised_b[ln] = 1'b0;
                    rescan_lines();
                end
            end
            default: ok = 1'b0;
        endcase
        if (!ok) rd = '0;
        r.read_data = rd;
        r.access_ok = ok;
        r.irq_request = irq_lvl;
        reply_q.insert(reply_q.size(), r);
    endtask

    // reset values of the shadow
    initial begin
        fail_count = 0;
        words_pending = 0;
        words_checked = 0;
        irq_seen = 0;
        ack_hits = 0;
        for (int n = 0; n < NUM_LINES; n++) begin
            en_b[n] = 0; pend_b[n] = 0; raised_b[n] = 0; prio_b[n] = 0;
            link_b[n] = NO_LINE;
        end
        for (int i = 0; i < 6; i++) trig_w[i] = '0;
        dist_on = 0; cpu_on = 0; pmask = '0; bpoint = BPR_RST;
        run_line = NO_LINE; run_prio = IDLE_PRIO; best_line = NO_LINE; irq_lvl = 0;
    end

    // predict on input, compare on output
    always @(posedge aclk) begin
        reply_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (reply_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result word rd=%h ok=%b irq=%b", $time,
                                 m_read_data, m_access_ok, m_irq_request);
                end else begin
                    want = reply_q.pop_front();
                    words_checked++;
                    if (m_irq_request) irq_seen++;
                    if (want.read_data !== m_read_data || want.access_ok !== m_access_ok ||
                        want.irq_request !== m_irq_request) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch exp rd=%h ok=%b irq=%b got rd=%h ok=%b irq=%b",
                                     $time, want.read_data, want.access_ok, want.irq_request,
                                     m_read_data, m_access_ok, m_irq_request);
                    end
                end
            end
            if (s_valid && s_ready)
                predict_word(s_action, s_offset, s_byte_count, s_write_data, s_line);
            words_pending = reply_q.size();
        end
    end
endmodule

// ===== tb/interrupt_distributor_cpu_interface_tb.sv =====
module interrupt_distributor_cpu_interface_tb;
    import idc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;

    logic        aclk, aresetn;
    logic        s_valid, s_ready;
    logic [2:0]  s_action;
    logic [11:0] s_offset;
    logic [2:0]  s_byte_count;
    logic [31:0] s_write_data;
    logic [6:0]  s_line;
    logic        m_valid, m_ready;
    logic [31:0] m_read_data;
    logic        m_access_ok, m_irq_request;
    int          fail_count, words_pending, words_checked, irq_seen, ack_hits;
    int          send_idle, recv_stall, idle_cycles;

    interrupt_distributor_cpu_interface uut (.*);

    interrupt_distributor_cpu_interface_checker chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // receiver stalls at the rate of the current phase
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall);

    // watchdog on acceptance
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("FAIL interrupt_distributor_cpu_interface");
            $finish;
        end
    end

    // valid stays up from one word to the next unless the sender idles
    task automatic send_word(input action_t act, input logic [11:0] off,
                             input logic [2:0] cnt, input logic [31:0] d,
                             input logic [6:0] ln);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_offset <= off;
        s_byte_count <= cnt;
        s_write_data <= d;
        s_line <= ln;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [11:0] pick_dist_offset();
        case ($urandom_range(11))
            0: return D_CTRL;
            1: return 12'(D_SET_EN + $urandom_range(8));
            2: return 12'(D_CLR_EN + $urandom_range(8));
            3: return 12'(D_SET_PEND + $urandom_range(8));
            4: return 12'(D_CLR_PEND + $urandom_range(8));
            5: return 12'(D_PRIO_LO + $urandom_range(92));
            6: return 12'(D_TGT_LO + $urandom_range(92));
            7: return 12'(D_TRIG_LO + $urandom_range(20));
            8: return 12'(D_ID0 + 4 * $urandom_range(3));
            9: return D_SGI;
            10: return D_TYPE;
            default: return 12'($urandom_range(4095));
        endcase
    endfunction

    task automatic random_word();
        int k;
        logic [31:0] d;
        k = $urandom_range(99);
        d = $urandom;
        if (k < 20)
            send_word(ACT_RAISE, 12'($urandom), 3'($urandom), d, 7'($urandom_range(99)));
        else if (k < 30)
            send_word(ACT_LOWER, 12'($urandom), 3'($urandom), d, 7'($urandom_range(99)));
        else if (k < 45)
            send_word(ACT_CPU_RD, $urandom_range(9) < 6 ? C_IAR : 12'(4 * $urandom_range(7)),
                      3'($urandom), d, 7'($urandom));
        else if (k < 57)
            send_word(ACT_CPU_WR, C_EOIR, 3'($urandom), $urandom_range(9) < 8 ?
                      $urandom_range(99) : d, 7'($urandom));
        else if (k < 62)
            send_word(ACT_CPU_WR, 12'(4 * $urandom_range(7)), 3'($urandom),
                      $urandom_range(1) ? 32'h1 : d, 7'($urandom));
        else if (k < 85)
            send_word(ACT_DIST_WR, pick_dist_offset(), 3'($urandom_range(7)), d,
                      7'($urandom));
        else if (k < 97)
            send_word(ACT_DIST_RD, pick_dist_offset(), 3'($urandom), d, 7'($urandom));
        else
            send_word(action_t'(3'($urandom_range(7, 6))), 12'($urandom), 3'($urandom), d,
                      7'($urandom));
    endtask

    initial begin
        int t;
        aresetn = 0;
        s_valid = 0; s_action = ACT_DIST_RD; s_offset = '0; s_byte_count = 3'd4;
        s_write_data = '0; s_line = '0; m_ready = 0;
        send_idle = 0; recv_stall = 0; idle_cycles = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: ids, enables, priorities, acknowledge chain, completions
        send_word(ACT_DIST_RD, D_ID0, 3'd4, '0, '0);
        send_word(ACT_DIST_RD, D_TYPE, 3'd1, '0, '0);
        send_word(ACT_CPU_RD, C_IAR, 3'd4, '0, '0);
        send_word(ACT_DIST_WR, D_CTRL, 3'd4, 32'hffff_ffff, '0);
        send_word(ACT_CPU_WR, C_CTRL, 3'd4, 32'h1, '0);
        send_word(ACT_CPU_WR, C_PMR, 3'd4, 32'hff, '0);
        send_word(ACT_CPU_WR, C_BPR, 3'd4, 32'hffff_ffff, '0);
        send_word(ACT_DIST_WR, D_PRIO_LO, 3'd7, 32'h10_20_30_40, '0);
        send_word(ACT_DIST_WR, D_PRIO_LO + 12'd92, 3'd4, 32'hff_80_01_fe, '0);
        send_word(ACT_DIST_WR, D_SET_EN, 3'd7, 32'hffff_ffff, '0);
        send_word(ACT_DIST_WR, D_SET_EN + 12'd8, 3'd4, 32'hffff_ffff, '0);
        send_word(ACT_RAISE, '0, '0, '0, 7'd95);
        send_word(ACT_RAISE, '0, '0, '0, 7'd127);
        send_word(ACT_DIST_WR, D_SET_PEND, 3'd1, 32'h0000_0002, '0);
        send_word(ACT_CPU_RD, C_HPPIR, 3'd4, '0, '0);
        send_word(ACT_CPU_RD, C_IAR, 3'd4, '0, '0);
        send_word(ACT_DIST_WR, D_PRIO_LO + 12'd4, 3'd1, 32'h00, '0);
        send_word(ACT_DIST_WR, D_SET_PEND, 3'd1, 32'h0000_0010, '0);
        send_word(ACT_CPU_RD, C_IAR, 3'd4, '0, '0);
        send_word(ACT_CPU_RD, C_RPR, 3'd4, '0, '0);
        send_word(ACT_CPU_WR, C_EOIR, 3'd4, 32'd1, '0);
        send_word(ACT_CPU_WR, C_EOIR, 3'd4, 32'd4, '0);
        send_word(ACT_CPU_WR, C_EOIR, 3'd4, 32'd200, '0);
        send_word(ACT_DIST_WR, D_TRIG_HI, 3'd4, 32'hdead_beef, '0);
        send_word(ACT_DIST_RD, D_TRIG_HI, 3'd4, '0, '0);

        // random phases with varying idle and stall rates
        for (int ph = 0; ph < 4; ph++) begin
            send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 51 : 23) : 0;
            recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 51 : 23) : 0;
            for (int i = 0; i < 100; i++) random_word();
            // hold off until every reply has come back
            s_valid <= 1'b0;
            t = 0;
            while (words_pending != 0 && t < 100000) begin
                @(posedge aclk);
                t++;
            end
        end
        recv_stall = 0;
        t = 0;
        while (words_pending != 0 && t < 100000) begin
            @(posedge aclk);
            t++;
        end
        repeat (300) @(posedge aclk);
        $display("Covered %0d result words, %0d with irq asserted, %0d acknowledges taken.",
                 words_checked, irq_seen, ack_hits);
        if (fail_count == 0 && words_pending == 0)
            $display("PASS interrupt_distributor_cpu_interface");
        else
            $display("FAIL interrupt_distributor_cpu_interface");
        $finish;
    end
endmodule

// ===== files.f =====
design/idc_pkg.sv
design/idc_ram.sv
design/interrupt_distributor_cpu_interface.sv
tb/interrupt_distributor_cpu_interface_checker.sv
tb/interrupt_distributor_cpu_interface_tb.sv
